// File: src/rcds_pkg.sv
// Shared types and constants for the cartridge ROM dump sequencer.
// Used by rcds_front, rcds_back and the top level.
`default_nettype none
package rcds_pkg;

  // Bank geometry and sampling
  localparam int BANK_OFFSET_BITS = 13;
  localparam int UNIFORM_SAMPLES  = 32;
  localparam int SAMPLE_W         = $clog2(UNIFORM_SAMPLES);
  localparam logic [15:0] SAMPLE_STRIDE = 16'h0107;

  // Header signature bytes
  localparam logic [7:0] SIG_HI = 8'hAA;
  localparam logic [7:0] SIG_LO = 8'h55;

  // Input opcodes
  localparam logic [1:0] OP_DETECT = 2'd0;
  localparam logic [1:0] OP_DUMP   = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_LENGTH   = 2'd0;
  localparam logic [1:0] REG_VERIFY_READS = 2'd1;

  localparam logic [15:0] MAX_LENGTH_RESET = 16'h8000;
  localparam int QUEUE_DEPTH = 2;

  // Command kinds held in the queue
  typedef enum logic [1:0] {
    CMD_DETECT,
    CMD_DUMP,
    CMD_DATA
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] data;
  } q_item_t;

  // Result record, first field in the highest bits
  typedef struct packed {
    logic [15:0]       total;
    logic signed [2:0] found_bank;
    logic              present;
    logic              done_res;
    logic [14:0]       byte_index;
    logic [7:0]        byte_value;
    logic              byte_valid;
    logic [12:0]       req_offset;
    logic [1:0]        req_bank;
    logic              req_valid;
  } res_t;

  localparam int RES_W   = $bits(res_t);
  localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage
`default_nettype wire

// File: src/rcds_front.sv
// Input side of the dump sequencer: accepts stream items, classifies the
// opcode and keeps a short queue for the back end. Uses rcds_pkg.
`default_nettype none
module rcds_front import rcds_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // read_data[7:0]
  input  wire logic [1:0] s_tuser,   // opcode[1:0]
  output logic            q_valid,
  output q_item_t         q_head,
  input  wire logic       q_pop
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  q_item_t             mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [PTR_W:0]      count;
  logic                keep;
  logic                push;
  logic                pop;
  q_item_t             item;

  // Classify the incoming opcode; the unused code is dropped here
  always_comb begin
    keep     = 1'b1;
    item.cmd = CMD_DATA;
    unique case (s_tuser)
      OP_DETECT: item.cmd = CMD_DETECT;
      OP_DUMP:   item.cmd = CMD_DUMP;
      OP_DATA:   item.cmd = CMD_DATA;
      default:   keep = 1'b0;
    endcase
    item.data = s_tdata;
  end

  assign s_tready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign push     = s_tvalid && s_tready && keep;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_head   = mem[rd_ptr];

  // Store the classified item
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/rcds_back.sv
// Execution side of the dump sequencer: runs detection and dump sequences
// on queued commands, holds configuration and the result register.
// Uses rcds_pkg.
`default_nettype none
module rcds_back import rcds_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  wire q_item_t     q_head,
  output logic             q_pop,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output res_t             res
);

  localparam int OB = BANK_OFFSET_BITS;
  localparam int SW = SAMPLE_W;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DETECT,
    PH_SAMPLE,
    PH_EMIT
  } phase_t;

  // Configuration
  logic [15:0] max_length;
  logic        verify_reads;

  // Sequencer state
  phase_t            phase, phase_next;
  logic [1:0]        bank_step, bank_step_next;
  logic [OB-1:0]     offset_count, offset_count_next;
  logic [SW-1:0]     sample_index, sample_index_next;
  logic [7:0]        lead_sample, lead_sample_next;
  logic [7:0]        header_first_byte, header_first_byte_next;
  logic signed [2:0] anchor_bank, anchor_bank_next;
  logic [15:0]       emitted_count, emitted_count_next;
  logic [1:0]        retry_count, retry_count_next;
  logic [7:0]        previous_read, previous_read_next;
  logic              have_prev, have_prev_next;
  logic [1:0]        cur_bank, cur_bank_next;
  logic [OB-1:0]     cur_off, cur_off_next;

  // Per-item working signals
  res_t          res_next;
  logic          slot_free;
  logic          drop;
  logic          run_byte;
  logic          go_emit;
  logic          iss;
  logic          fin;
  logic [1:0]    iss_bank;
  logic [OB-1:0] iss_off;
  logic [7:0]    bv;
  logic [SW:0]   si_inc;
  logic [OB:0]   oc_inc;
  logic [15:0]   em_inc;
  logic [31:0]   sample_prod;
  logic [1:0]    first_bank;

  // Bank visited at a given step of the dump
  function automatic logic [1:0] dump_bank(input logic [1:0] first, input logic [1:0] step);
    return first + step;
  endfunction

  assign first_bank = (!anchor_bank[2] && anchor_bank != 3'sd0) ? anchor_bank[1:0] : 2'd0;
  assign slot_free  = !m_tvalid || m_tready;
  assign q_pop      = q_valid && slot_free;
  assign si_inc     = {1'b0, sample_index} + (SW+1)'(1);
  assign oc_inc     = {1'b0, offset_count} + (OB+1)'(1);
  assign em_inc     = emitted_count + 16'd1;
  assign sample_prod = 32'(si_inc) * 32'(SAMPLE_STRIDE);

  // Work out the next state and the result for the head command
  always_comb begin
    phase_next             = phase;
    bank_step_next         = bank_step;
    offset_count_next      = offset_count;
    sample_index_next      = sample_index;
    lead_sample_next       = lead_sample;
    header_first_byte_next = header_first_byte;
    anchor_bank_next       = anchor_bank;
    emitted_count_next     = emitted_count;
    retry_count_next       = retry_count;
    previous_read_next     = previous_read;
    have_prev_next         = have_prev;
    cur_bank_next          = cur_bank;
    cur_off_next           = cur_off;
    res_next               = '0;
    drop                   = 1'b0;
    run_byte               = 1'b0;
    go_emit                = 1'b0;
    iss                    = 1'b0;
    fin                    = 1'b0;
    iss_bank               = 2'd0;
    iss_off                = '0;
    bv                     = q_head.data;

    unique case (q_head.cmd)
      CMD_DETECT: begin
        anchor_bank_next  = -3'sd1;
        phase_next        = PH_DETECT;
        bank_step_next    = 2'd0;
        offset_count_next = '0;
        iss               = 1'b1;
      end
      CMD_DUMP: begin
        emitted_count_next = 16'd0;
        bank_step_next     = 2'd0;
        phase_next         = PH_SAMPLE;
        sample_index_next  = '0;
        iss                = 1'b1;
        iss_bank           = dump_bank(first_bank, 2'd0);
      end
      CMD_DATA: begin
        if (phase == PH_IDLE) begin
          drop = 1'b1;
        end else if (!verify_reads) begin
          run_byte = 1'b1;
        end else if (!have_prev) begin
          // First read of a verified pair: repeat the request
          previous_read_next = bv;
          have_prev_next     = 1'b1;
          retry_count_next   = 2'd0;
          res_next.req_valid = 1'b1;
          res_next.req_bank  = cur_bank;
          res_next.req_offset = 13'(cur_off);
        end else if (bv == previous_read) begin
          run_byte = 1'b1;
        end else begin
          previous_read_next = bv;
          if (retry_count >= 2'd2) begin
            run_byte = 1'b1;
          end else begin
            retry_count_next    = retry_count + 2'd1;
            res_next.req_valid  = 1'b1;
            res_next.req_bank   = cur_bank;
            res_next.req_offset = 13'(cur_off);
          end
        end
      end
      default: drop = 1'b1;
    endcase

    // Handle a returned byte according to the running sequence
    if (run_byte) begin
      case (phase)
        PH_DETECT: begin
          if (offset_count == '0) begin
            header_first_byte_next = bv;
            offset_count_next      = OB'(1);
            iss                    = 1'b1;
            iss_bank               = bank_step;
            iss_off                = OB'(1);
          end else if ((header_first_byte == SIG_HI && bv == SIG_LO) ||
                       (header_first_byte == SIG_LO && bv == SIG_HI)) begin
            anchor_bank_next = $signed({1'b0, bank_step});
            fin              = 1'b1;
          end else if (bank_step == 2'd3) begin
            fin = 1'b1;
          end else begin
            bank_step_next    = bank_step + 2'd1;
            offset_count_next = '0;
            iss               = 1'b1;
            iss_bank          = bank_step + 2'd1;
          end
        end
        PH_SAMPLE: begin
          if (sample_index != '0 && bv != lead_sample) begin
            go_emit = 1'b1;
          end else begin
            if (sample_index == '0) begin
              lead_sample_next = bv;
            end
            sample_index_next = si_inc[SW-1:0];
            if (32'(si_inc) < 32'(UNIFORM_SAMPLES)) begin
              iss      = 1'b1;
              iss_bank = dump_bank(first_bank, bank_step);
              iss_off  = sample_prod[OB-1:0];
            end else if (bank_step != 2'd0) begin
              fin = 1'b1;
            end else begin
              go_emit = 1'b1;
            end
          end
        end
        PH_EMIT: begin
          res_next.byte_valid = 1'b1;
          res_next.byte_value = bv;
          res_next.byte_index = emitted_count[14:0];
          emitted_count_next  = em_inc;
          offset_count_next   = oc_inc[OB-1:0];
          if (oc_inc[OB]) begin
            if (bank_step == 2'd3) begin
              fin = 1'b1;
            end else begin
              bank_step_next    = bank_step + 2'd1;
              phase_next        = PH_SAMPLE;
              sample_index_next = '0;
              iss               = 1'b1;
              iss_bank          = dump_bank(first_bank, bank_step + 2'd1);
            end
          end else if (em_inc >= max_length) begin
            fin = 1'b1;
          end else begin
            iss      = 1'b1;
            iss_bank = dump_bank(first_bank, bank_step);
            iss_off  = oc_inc[OB-1:0];
          end
        end
        default: ;
      endcase
    end

    // Start emitting the current bank
    if (go_emit) begin
      phase_next        = PH_EMIT;
      offset_count_next = '0;
      if (emitted_count >= max_length) begin
        fin = 1'b1;
      end else begin
        iss      = 1'b1;
        iss_bank = dump_bank(first_bank, bank_step);
      end
    end

    // Issue a fresh read request
    if (iss) begin
      cur_bank_next       = iss_bank;
      cur_off_next        = iss_off;
      have_prev_next      = 1'b0;
      retry_count_next    = 2'd0;
      res_next.req_valid  = 1'b1;
      res_next.req_bank   = iss_bank;
      res_next.req_offset = 13'(iss_off);
    end

    if (fin) begin
      phase_next        = PH_IDLE;
      res_next.done_res = 1'b1;
    end

    res_next.present    = !anchor_bank_next[2];
    res_next.found_bank = anchor_bank_next;
    res_next.total      = emitted_count_next;
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (slot_free && q_valid && !drop) begin
      res <= res_next;
    end
  end

  // Sequencer registers, configuration and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_IDLE;
      bank_step         <= 2'd0;
      offset_count      <= '0;
      sample_index      <= '0;
      lead_sample       <= 8'd0;
      header_first_byte <= 8'd0;
      anchor_bank       <= -3'sd1;
      emitted_count     <= 16'd0;
      retry_count       <= 2'd0;
      previous_read     <= 8'd0;
      have_prev         <= 1'b0;
      cur_bank          <= 2'd0;
      cur_off           <= '0;
      max_length        <= MAX_LENGTH_RESET;
      verify_reads      <= 1'b0;
      m_tvalid          <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_MAX_LENGTH:   max_length   <= cfg_data;
          REG_VERIFY_READS: verify_reads <= cfg_data[0];
          default: ;
        endcase
      end
      if (slot_free) begin
        m_tvalid <= q_valid && !drop;
      end
      if (q_pop) begin
        phase             <= phase_next;
        bank_step         <= bank_step_next;
        offset_count      <= offset_count_next;
        sample_index      <= sample_index_next;
        lead_sample       <= lead_sample_next;
        header_first_byte <= header_first_byte_next;
        anchor_bank       <= anchor_bank_next;
        emitted_count     <= emitted_count_next;
        retry_count       <= retry_count_next;
        previous_read     <= previous_read_next;
        have_prev         <= have_prev_next;
        cur_bank          <= cur_bank_next;
        cur_off           <= cur_off_next;
      end
    end
  end

endmodule
`default_nettype wire

// File: src/rom_cartridge_dump_sequencer.sv
// Cartridge ROM dump sequencer, top level: front queue plus sequencer back end.
// Depends on rcds_pkg, rcds_front and rcds_back.
//
// Commands and returned bytes enter on the s_ stream (opcode in tuser, byte in
// tdata); each command or byte that is not ignored gives one result on the m_
// stream, carrying the next read request, any dumped byte and status. The block
// takes one item per cycle while the queue has room: a two-entry queue decouples
// the input from the sequencer, which handles the queue head whenever the result
// register is free or being taken and registers its result as the head is taken.
// Opcode 3, and returned data while no sequence runs, produce no result.
// Configuration writes are taken at any time (cfg_ready stays high) but must
// only be made while the block is idle.
`default_nettype none
module rom_cartridge_dump_sequencer import rcds_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,   // read_data[7:0]
  input  wire logic [1:0]         s_tuser,   // opcode[1:0]
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // req_valid[0], req_bank[2:1], req_offset[15:3], byte_valid[16],
  // byte_value[24:17], byte_index[39:25], done_res[40], present[41],
  // found_bank[44:42], total[60:45], zero fill above
  output logic [TDATA_W-1:0]      m_tdata,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  logic    q_valid;
  logic    q_pop;
  q_item_t q_head;
  res_t    res;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{(TDATA_W-RES_W){1'b0}}, res};

  rcds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  rcds_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .res       (res)
  );

endmodule
`default_nettype wire
